/* design/pstg_pkg.sv */
// Package: shared types, codes, constants and sine table function.
`timescale 1ns / 1ps
package pstg_pkg;

    // Request codes
    localparam int REQ_TYPE_BITS = 2;
    localparam int KEY_INDEX_BITS = 3;

    typedef enum logic [REQ_TYPE_BITS-1:0] {
        REQ_TICK     = 2'd0,
        REQ_KEY_DOWN = 2'd1,
        REQ_KEY_UP   = 2'd2
    } req_type_t;

    // Config port
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_GAIN      = 4'd0,
        CFG_STEP_BASE = 4'd1
    } cfg_index_t;

    // Gain and register resets
    localparam int GAIN_BITS = 16;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd19661;
    localparam int ROUND_HALF = 1 << (GAIN_BITS - 1);

    localparam int DEFAULT_VOICES = 7;
    localparam logic [31:0] STEP_RESET [DEFAULT_VOICES] = '{
        32'd25480551, 32'd28600003, 32'd32103177, 32'd34012051,
        32'd38177488, 32'd42852282, 32'd48099739
    };

    // Cycles from last issue into the mixer until the sum is final
    localparam int DRAIN_CYCLES = 2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Per-cell control
    typedef struct packed {
        logic shift;
        logic key_down;
        logic key_up;
        logic step_wr;
    } cell_ctrl_t;

    // Sine table generation (elaboration only)
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam int SERIES_TERMS = 7;
    localparam logic [63:0] SERIES_DIV [SERIES_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    function automatic longint quarter_sine(longint p, int addr_bits, longint amp);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        longint acc;
        x    = (PI_Q30 * 64'd2 * 64'(p)) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 0; k < SERIES_TERMS; k++)
        begin
            term = ((term * x2) >> 30) / SERIES_DIV[k];
            if ((k & 1) == 0)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        mag = (64'(acc) * 64'(amp) + (64'd1 << 29)) >> 30;
        if (mag > 64'(amp))
            mag = 64'(amp);
        return longint'(mag);
    endfunction

    function automatic longint sine_entry(int idx, int addr_bits, int sample_bits);
        longint n;
        longint q;
        longint h;
        longint amp;
        longint i;
        n   = longint'(1) << addr_bits;
        q   = longint'(1) << (addr_bits - 2);
        h   = longint'(1) << (addr_bits - 1);
        amp = (longint'(1) << (sample_bits - 1)) - 1;
        i   = longint'(idx);
        if (i < q)
            return quarter_sine(i, addr_bits, amp);
        else if (i < h)
            return quarter_sine(h - i, addr_bits, amp);
        else if (i < h + q)
            return -quarter_sine(i - h, addr_bits, amp);
        else
            return -quarter_sine(n - i, addr_bits, amp);
    endfunction

endpackage

/* design/pstg_if.sv */
// Interfaces: request, config and audio sample channels.
`timescale 1ns / 1ps
interface pstg_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [pstg_pkg::REQ_TYPE_BITS-1:0]   req_type;
    logic [pstg_pkg::KEY_INDEX_BITS-1:0]  key_index;

    modport source (output valid, output req_type, output key_index, input ready);
    modport sink   (input valid, input req_type, input key_index, output ready);
endinterface

interface pstg_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [pstg_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [pstg_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface pstg_audio_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* design/pstg_voice_cell.sv */
// Voice cell: on flag, phase and tone step of one voice slot in the ring.
`timescale 1ns / 1ps
module pstg_voice_cell #(
    parameter int PHASE_BITS = 32,
    parameter logic [PHASE_BITS-1:0] RESET_STEP = '0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pstg_pkg::cell_ctrl_t   ctrl,
    input  logic [PHASE_BITS-1:0]  step_data,
    input  logic                   nxt_on,
    input  logic [PHASE_BITS-1:0]  nxt_phase,
    input  logic [PHASE_BITS-1:0]  nxt_step,
    output logic                   on,
    output logic [PHASE_BITS-1:0]  phase,
    output logic [PHASE_BITS-1:0]  step
);
    import pstg_pkg::*;

    logic                  on_reg, on_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PHASE_BITS-1:0] step_reg, step_next;

    always_comb
    begin
        on_next    = on_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        if (ctrl.shift)
        begin
            on_next    = nxt_on;
            phase_next = nxt_phase;
            step_next  = nxt_step;
        end
        else
        begin
            if (ctrl.key_down)
                on_next = 1'b1;
            if (ctrl.key_up)
            begin
                on_next    = 1'b0;
                phase_next = '0;
            end
            if (ctrl.step_wr)
                step_next = step_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_reg    <= 1'b0;
            phase_reg <= '0;
            step_reg  <= RESET_STEP;
        end
        else
        begin
            on_reg    <= on_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    assign on    = on_reg;
    assign phase = phase_reg;
    assign step  = step_reg;

endmodule

/* design/pstg_sine_rom.sv */
// Sine ROM: full-wave signed table, registered read.
`timescale 1ns / 1ps
module pstg_sine_rom #(
    parameter int ADDR_BITS   = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic [ADDR_BITS-1:0]          addr,
    output logic signed [SAMPLE_BITS-1:0] data
);
    import pstg_pkg::*;

    localparam int TABLE_SIZE = 1 << ADDR_BITS;

    logic signed [SAMPLE_BITS-1:0] rom_tbl [TABLE_SIZE];
    logic signed [SAMPLE_BITS-1:0] data_reg;

    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_tbl
        assign rom_tbl[i] = SAMPLE_BITS'(sine_entry(i, ADDR_BITS, SAMPLE_BITS));
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_tbl[addr];
    end

    assign data = data_reg;

endmodule

/* design/pstg_mixer.sv */
// Mixer: sine lookup, gain multiply, rounding, signed accumulate and clamp to full scale.
`timescale 1ns / 1ps
module pstg_mixer #(
    parameter int NUM_VOICES     = 7,
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  logic                                 issue,
    input  logic [PHASE_BITS-1:0]                phase,
    input  logic [pstg_pkg::GAIN_BITS-1:0]       gain,
    output logic signed [SAMPLE_BITS-1:0]        sample
);
    import pstg_pkg::*;

    localparam int MAG_BITS  = SAMPLE_BITS - 1;
    localparam int PROD_BITS = MAG_BITS + GAIN_BITS;
    localparam int ACC_BITS  = SAMPLE_BITS + $clog2(NUM_VOICES + 1) + 1;
    localparam logic signed [ACC_BITS-1:0] FULL_POS =
        ACC_BITS'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] FULL_NEG = -FULL_POS;

    logic signed [SAMPLE_BITS-1:0] tbl_data;
    logic                          s1_valid_reg;
    logic                          s2_valid_reg;
    logic                          neg_reg;
    logic [PROD_BITS-1:0]          prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg, acc_next;

    logic [SAMPLE_BITS-1:0]        tbl_abs;
    logic [PROD_BITS:0]            rnd_sum;
    logic [ACC_BITS-1:0]           contrib;

    pstg_sine_rom #(
        .ADDR_BITS   (SINE_ADDR_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_rom (
        .clk  (clk),
        .addr (phase[PHASE_BITS-1 -: SINE_ADDR_BITS]),
        .data (tbl_data)
    );

    // magnitude never exceeds full scale, so top bit drops
    assign tbl_abs = tbl_data[SAMPLE_BITS-1] ? SAMPLE_BITS'(-tbl_data)
                                             : SAMPLE_BITS'(tbl_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_BITS'(tbl_abs[MAG_BITS-1:0] * gain);
        neg_reg  <= tbl_data[SAMPLE_BITS-1];
    end

    // round half up on the magnitude = ties away from zero
    assign rnd_sum = {1'b0, prod_reg} + (PROD_BITS + 1)'(ROUND_HALF);
    assign contrib = ACC_BITS'(rnd_sum[PROD_BITS:GAIN_BITS]);

    always_comb
    begin
        acc_next = acc_reg;
        if (clear)
            acc_next = '0;
        else if (s2_valid_reg)
            acc_next = neg_reg ? (acc_reg - signed'(contrib))
                               : (acc_reg + signed'(contrib));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    always_comb
    begin
        if (acc_reg > FULL_POS)
            sample = FULL_POS[SAMPLE_BITS-1:0];
        else if (acc_reg < FULL_NEG)
            sample = FULL_NEG[SAMPLE_BITS-1:0];
        else
            sample = acc_reg[SAMPLE_BITS-1:0];
    end

endmodule

/* design/polyphonic_sine_tone_generator.sv */
// Top level: voice cell ring, shared mixer, sequencer and output register.
//
//  channel | modport | beat carries            | accepted when
//  --------+---------+-------------------------+----------------------
//  req     | sink    | req_type, key_index     | req.valid & req.ready
//  cfg     | sink    | index, data             | cfg.valid & cfg.ready
//  audio   | source  | sample                  | audio.valid & audio.ready
//
// A key beat is handled in idle and leaves the sequencer there. A tick beat
// holds the request side from its accepting edge until the sequencer is back
// in idle: the voice ring rotates once through the single sine/gain unit,
// one voice per cycle, the mixer pipeline drains, the done state loads the
// output register and the sequencer returns to idle. The sample is valid
// once the output register is loaded.
// The finished sample lands in an output register; a new request is taken
// while it waits, and a following tick stalls only at its end until the
// register frees up. rst_n clears all voices and restores default gain and
// tone steps. cfg is always ready.
`timescale 1ns / 1ps
module polyphonic_sine_tone_generator #(
    parameter int NUM_VOICES     = 7,
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pstg_req_if.sink      req,
    pstg_cfg_if.sink      cfg,
    pstg_audio_if.source  audio
);
    import pstg_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_VOICES + DRAIN_CYCLES);

    // Sequencer
    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  req_fire;
    logic                  cfg_fire;
    logic                  is_tick;
    logic                  in_ready;
    logic                  rotate;
    logic                  clear_acc;
    logic                  load_out;

    // Config
    logic [GAIN_BITS-1:0]  gain_reg, gain_next;

    // Voice ring
    cell_ctrl_t            cell_ctrl [NUM_VOICES];
    logic                  cell_on [NUM_VOICES];
    logic [PHASE_BITS-1:0] cell_phase [NUM_VOICES];
    logic [PHASE_BITS-1:0] cell_step [NUM_VOICES];
    logic [PHASE_BITS-1:0] head_phase_adv;

    // Output
    logic signed [SAMPLE_BITS-1:0] mix_sample;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    assign req_fire = req.valid && in_ready;
    assign cfg_fire = cfg.valid;
    assign is_tick  = (req.req_type == REQ_TICK);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (req_fire && is_tick)
                    state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                if (cnt_reg == CNT_BITS'(NUM_VOICES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DRAIN:
            begin
                if (cnt_reg == CNT_BITS'(DRAIN_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || audio.ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        rotate    = 1'b0;
        clear_acc = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                clear_acc = req.valid && is_tick;
            end
            ST_ROTATE:
                rotate = 1'b1;
            ST_DRAIN:
                rotate = 1'b0;
            ST_DONE:
                load_out = !out_valid_reg || audio.ready;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign req.ready = in_ready;
    assign cfg.ready = 1'b1;

    // gain register
    always_comb
    begin
        gain_next = gain_reg;
        if (cfg_fire && cfg.index == CFG_GAIN)
            gain_next = cfg.data[GAIN_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else
            gain_reg <= gain_next;
    end

    // Ring: cell i pulls from cell i+1; the last cell takes the head voice
    // back with its phase advanced (when on).
    assign head_phase_adv = cell_on[0] ? PHASE_BITS'(cell_phase[0] + cell_step[0])
                                       : cell_phase[0];

    for (genvar i = 0; i < NUM_VOICES; i++)
    begin : g_cell
        localparam logic [PHASE_BITS-1:0] RST_STEP =
            (i < DEFAULT_VOICES) ? STEP_RESET[i % DEFAULT_VOICES][PHASE_BITS-1:0] : '0;

        logic                  nb_on;
        logic [PHASE_BITS-1:0] nb_phase;
        logic [PHASE_BITS-1:0] nb_step;
        logic                  key_hit;
        logic                  step_hit;

        assign key_hit = req_fire && (int'(req.key_index) == i);

        if (i < DEFAULT_VOICES)
        begin : g_wr
            assign step_hit = cfg_fire &&
                (cfg.index == CFG_INDEX_BITS'(int'(CFG_STEP_BASE) + i));
        end
        else
        begin : g_nowr
            assign step_hit = 1'b0;
        end

        if (i == NUM_VOICES - 1)
        begin : g_tail
            assign nb_on    = cell_on[0];
            assign nb_phase = head_phase_adv;
            assign nb_step  = cell_step[0];
        end
        else
        begin : g_mid
            assign nb_on    = cell_on[i+1];
            assign nb_phase = cell_phase[i+1];
            assign nb_step  = cell_step[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].shift    = rotate;
            cell_ctrl[i].key_down = key_hit && (req.req_type == REQ_KEY_DOWN);
            cell_ctrl[i].key_up   = key_hit && (req.req_type == REQ_KEY_UP);
            cell_ctrl[i].step_wr  = step_hit;
        end

        pstg_voice_cell #(
            .PHASE_BITS (PHASE_BITS),
            .RESET_STEP (RST_STEP)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .step_data (cfg.data[PHASE_BITS-1:0]),
            .nxt_on    (nb_on),
            .nxt_phase (nb_phase),
            .nxt_step  (nb_step),
            .on        (cell_on[i]),
            .phase     (cell_phase[i]),
            .step      (cell_step[i])
        );
    end

    // Shared lookup / multiply / accumulate on the head voice
    pstg_mixer #(
        .NUM_VOICES     (NUM_VOICES),
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_mixer (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (clear_acc),
        .issue  (rotate && cell_on[0]),
        .phase  (cell_phase[0]),
        .gain   (gain_reg),
        .sample (mix_sample)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (audio.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            sample_reg <= mix_sample;
    end

    assign audio.valid  = out_valid_reg;
    assign audio.sample = sample_reg;

endmodule
